[hw/rtl/dtwl1_pkg.sv]
// dtwl1_pkg: shared types and constants of the dtw l1 frame alignment cost block
// holds register indexes, register widths and reset values, cost limits and alu op codes
// no dependencies
package dtwl1_pkg;

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 9;

    localparam logic [CFG_AW-1:0] CFG_X_FRAMES    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_Y_FRAMES    = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_COEFF_COUNT = 2'd2;

    localparam int FRAMES_REG_W = 9;
    localparam int COEFFS_REG_W = 5;

    localparam logic [FRAMES_REG_W-1:0] X_FRAMES_RESET    = 9'd256;
    localparam logic [FRAMES_REG_W-1:0] Y_FRAMES_RESET    = 9'd256;
    localparam logic [COEFFS_REG_W-1:0] COEFF_COUNT_RESET = 5'd12;

    // path cost
    localparam int              COST_W   = 32;
    localparam logic [COST_W-1:0] COST_MAX = 32'hFFFF_FFFF;

    // shared adder operations
    typedef enum logic {
        ALU_ACC_DIFF,
        ALU_ADD_BEST
    } alu_op_t;

endpackage

[hw/rtl/dtw_l1_frame_alignment_cost_top.sv]
// dtw_l1_frame_alignment_cost_top: top level of the dtw l1 frame alignment cost block
// loads both sequences, starts the cost walk and holds the result word
// depends on dtwl1_pkg, dtwl1_coeff_mem and dtwl1_seq
//
// Usage:
//   s_ channel: one coefficient word per beat; s_tuser selects the sequence
//   (0 = X, 1 = Y), s_tdata holds the coefficient. Each sequence is sent in
//   frame-major order; words beyond a full sequence are dropped.
//   Words are taken back to back while s_tready is high.
//   When both sequences hold x_frames*coeff_count and y_frames*coeff_count
//   words, s_tready drops and the walk runs over every cell, with the shared
//   adder taking one coefficient pair a cycle.
//   m_ channel: one cost word per completed pair of sequences; the result
//   stays in the output register while m_tready is low, and loading of the
//   next pair goes on meanwhile. A walk that ends while the previous result
//   is still waiting holds its cost until the output register frees.
//   cfg port: write x_frames, y_frames, coeff_count only while idle.
//   Reset: load counts clear and registers take 256, 256, 12; the stores are
//   not cleared and need no clearing pass.
module dtw_l1_frame_alignment_cost_top #(
    parameter int MAX_FRAMES  = 256,
    parameter int MAX_COEFFS  = 16,
    parameter int COEFF_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [((COEFF_WIDTH + 7) / 8) * 8 - 1:0] s_tdata, // [COEFF_WIDTH-1:0] coeff_value
    input  logic                            s_tuser,   // [0] which_sequence
    // result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dtwl1_pkg::COST_W-1:0]    m_tdata,   // [31:0] warp_cost
    // configuration writes
    input  logic                            cfg_we,
    input  logic [dtwl1_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [dtwl1_pkg::CFG_DW-1:0]    cfg_wdata
);

    localparam int DEPTH   = MAX_FRAMES * MAX_COEFFS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int FW      = $clog2(MAX_FRAMES + 1);
    localparam int DW      = $clog2(MAX_COEFFS + 1);

    typedef enum logic [1:0] {
        T_LOAD,
        T_RUN,
        T_HOLD
    } state_t;

    state_t                             state_reg;
    logic                               m_tvalid_reg;
    logic [dtwl1_pkg::COST_W-1:0]       m_tdata_reg;
    logic [dtwl1_pkg::COST_W-1:0]       hold_cost_reg;
    logic                               seq_start_reg;

    logic [dtwl1_pkg::FRAMES_REG_W-1:0] x_frames_reg;
    logic [dtwl1_pkg::FRAMES_REG_W-1:0] y_frames_reg;
    logic [dtwl1_pkg::COEFFS_REG_W-1:0] coeff_count_reg;
    logic [CNT_W-1:0]                   x_cnt_reg;
    logic [CNT_W-1:0]                   y_cnt_reg;

    logic [FW-1:0]                      n_eff;
    logic [FW-1:0]                      m_eff;
    logic [DW-1:0]                      d_eff;
    logic [CNT_W-1:0]                   x_total;
    logic [CNT_W-1:0]                   y_total;
    logic                               accept;
    logic                               x_wr;
    logic                               y_wr;
    logic [CNT_W-1:0]                   x_cnt_next;
    logic [CNT_W-1:0]                   y_cnt_next;
    logic                               loaded;
    logic                               out_free;

    logic                               rd_en;
    logic [AW-1:0]                      x_rd_addr;
    logic [AW-1:0]                      y_rd_addr;
    logic signed [COEFF_WIDTH-1:0]      x_rd_data;
    logic signed [COEFF_WIDTH-1:0]      y_rd_data;
    logic                               seq_done;
    logic [dtwl1_pkg::COST_W-1:0]       seq_cost;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_frames_reg    <= dtwl1_pkg::X_FRAMES_RESET;
            y_frames_reg    <= dtwl1_pkg::Y_FRAMES_RESET;
            coeff_count_reg <= dtwl1_pkg::COEFF_COUNT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                dtwl1_pkg::CFG_X_FRAMES:    x_frames_reg    <= cfg_wdata;
                dtwl1_pkg::CFG_Y_FRAMES:    y_frames_reg    <= cfg_wdata;
                dtwl1_pkg::CFG_COEFF_COUNT:
                    coeff_count_reg <= cfg_wdata[dtwl1_pkg::COEFFS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // effective counts: zero acts as one, overlarge acts as the maximum
    always_comb begin
        if (x_frames_reg == '0) begin
            n_eff = FW'(1);
        end else if (x_frames_reg > MAX_FRAMES) begin
            n_eff = FW'(MAX_FRAMES);
        end else begin
            n_eff = FW'(x_frames_reg);
        end
        if (y_frames_reg == '0) begin
            m_eff = FW'(1);
        end else if (y_frames_reg > MAX_FRAMES) begin
            m_eff = FW'(MAX_FRAMES);
        end else begin
            m_eff = FW'(y_frames_reg);
        end
        if (coeff_count_reg == '0) begin
            d_eff = DW'(1);
        end else if (coeff_count_reg > MAX_COEFFS) begin
            d_eff = DW'(MAX_COEFFS);
        end else begin
            d_eff = DW'(coeff_count_reg);
        end
        x_total = CNT_W'(n_eff) * CNT_W'(d_eff);
        y_total = CNT_W'(m_eff) * CNT_W'(d_eff);
    end

    // load bookkeeping
    assign s_tready   = (state_reg == T_LOAD);
    assign accept     = s_tvalid && s_tready;
    assign x_wr       = accept && !s_tuser && (x_cnt_reg < x_total);
    assign y_wr       = accept && s_tuser && (y_cnt_reg < y_total);
    assign x_cnt_next = x_cnt_reg + CNT_W'(x_wr);
    assign y_cnt_next = y_cnt_reg + CNT_W'(y_wr);
    assign loaded     = accept && (x_cnt_next >= x_total) && (y_cnt_next >= y_total);
    assign out_free   = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_cnt_reg <= '0;
            y_cnt_reg <= '0;
        end else if (loaded) begin
            x_cnt_reg <= '0;
            y_cnt_reg <= '0;
        end else begin
            x_cnt_reg <= x_cnt_next;
            y_cnt_reg <= y_cnt_next;
        end
    end

    // coefficient stores
    dtwl1_coeff_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (COEFF_WIDTH)
    ) u_x_mem (
        .aclk    (aclk),
        .wr_en   (x_wr),
        .wr_addr (x_cnt_reg[AW-1:0]),
        .wr_data (s_tdata[COEFF_WIDTH-1:0]),
        .rd_en   (rd_en),
        .rd_addr (x_rd_addr),
        .rd_data (x_rd_data)
    );

    dtwl1_coeff_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (COEFF_WIDTH)
    ) u_y_mem (
        .aclk    (aclk),
        .wr_en   (y_wr),
        .wr_addr (y_cnt_reg[AW-1:0]),
        .wr_data (s_tdata[COEFF_WIDTH-1:0]),
        .rd_en   (rd_en),
        .rd_addr (y_rd_addr),
        .rd_data (y_rd_data)
    );

    // cost walk
    dtwl1_seq #(
        .MAX_FRAMES  (MAX_FRAMES),
        .MAX_COEFFS  (MAX_COEFFS),
        .COEFF_WIDTH (COEFF_WIDTH),
        .FW          (FW),
        .DW          (DW),
        .AW          (AW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (seq_start_reg),
        .n_frames  (n_eff),
        .m_frames  (m_eff),
        .d_coeffs  (d_eff),
        .rd_en     (rd_en),
        .x_rd_addr (x_rd_addr),
        .y_rd_addr (y_rd_addr),
        .x_rd_data (x_rd_data),
        .y_rd_data (y_rd_data),
        .done      (seq_done),
        .cost      (seq_cost)
    );

    // control and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_LOAD;
            m_tvalid_reg  <= 1'b0;
            seq_start_reg <= 1'b0;
        end else begin
            seq_start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                T_LOAD: begin
                    if (loaded) begin
                        state_reg     <= T_RUN;
                        seq_start_reg <= 1'b1;
                    end
                end
                T_RUN: begin
                    if (seq_done) begin
                        if (out_free) begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= seq_cost;
                            state_reg    <= T_LOAD;
                        end else begin
                            hold_cost_reg <= seq_cost;
                            state_reg     <= T_HOLD;
                        end
                    end
                end
                T_HOLD: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= hold_cost_reg;
                        state_reg    <= T_LOAD;
                    end
                end
                default: begin
                    state_reg <= T_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // a walk starts only with both load counts already cleared
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_start_reg |-> (x_cnt_reg == '0) && (y_cnt_reg == '0) && (state_reg == T_RUN))
        else $error("walk started with nonzero load counts");

    // the walk reports completion only while a walk is outstanding
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_done |-> (state_reg == T_RUN))
        else $error("walk done outside run state");

    // a held cost implies the previous result is still pending
    a_hold_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_HOLD) |-> m_tvalid_reg)
        else $error("cost held while output register free");

    // no word is taken while the walk runs
    a_no_load_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_RUN) |-> !x_wr && !y_wr)
        else $error("store written during walk");
`endif

endmodule

[hw/rtl/dtwl1_coeff_mem.sv]
// dtwl1_coeff_mem: coefficient store of one sequence, one write and one read port
// read data is registered; contents are undefined until written
// depends on nothing
module dtwl1_coeff_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int W     = 16
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic signed [W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic signed [W-1:0] rd_data
);

    logic signed [W-1:0] mem [DEPTH];
    logic signed [W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/dtwl1_alu.sv]
// dtwl1_alu: shared saturating adder of the cost walk
// adds either an absolute coefficient difference or the best neighbor cost
// depends on dtwl1_pkg
module dtwl1_alu #(
    parameter int COEFF_WIDTH = 16
) (
    input  dtwl1_pkg::alu_op_t                 op,
    input  logic [dtwl1_pkg::COST_W-1:0]       acc_in,
    input  logic signed [COEFF_WIDTH-1:0]      coeff_a,
    input  logic signed [COEFF_WIDTH-1:0]      coeff_b,
    input  logic [dtwl1_pkg::COST_W-1:0]       best,
    output logic [dtwl1_pkg::COST_W-1:0]       sum
);

    logic signed [COEFF_WIDTH:0]    diff;
    logic [COEFF_WIDTH-1:0]         abs_diff;
    logic [dtwl1_pkg::COST_W-1:0]   addend;
    logic [dtwl1_pkg::COST_W:0]     raw;

    // absolute difference, one bit wider to avoid overflow
    always_comb begin
        diff     = {coeff_a[COEFF_WIDTH-1], coeff_a} - {coeff_b[COEFF_WIDTH-1], coeff_b};
        abs_diff = diff[COEFF_WIDTH] ? COEFF_WIDTH'(-diff) : diff[COEFF_WIDTH-1:0];
    end

    // operand select
    always_comb begin
        case (op)
            dtwl1_pkg::ALU_ACC_DIFF: addend = dtwl1_pkg::COST_W'(abs_diff);
            dtwl1_pkg::ALU_ADD_BEST: addend = best;
            default:                 addend = best;
        endcase
    end

    // saturating add
    always_comb begin
        raw = {1'b0, acc_in} + {1'b0, addend};
        sum = raw[dtwl1_pkg::COST_W] ? dtwl1_pkg::COST_MAX : raw[dtwl1_pkg::COST_W-1:0];
    end

endmodule

[hw/rtl/dtwl1_seq.sv]
// dtwl1_seq: sequencer of the warping cost walk over the n x m cell grid
// holds the previous row cost memory and drives the shared adder and store reads
// depends on dtwl1_pkg and dtwl1_alu
module dtwl1_seq #(
    parameter int MAX_FRAMES  = 256,
    parameter int MAX_COEFFS  = 16,
    parameter int COEFF_WIDTH = 16,
    parameter int FW          = 9,
    parameter int DW          = 5,
    parameter int AW          = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [FW-1:0]                   n_frames,
    input  logic [FW-1:0]                   m_frames,
    input  logic [DW-1:0]                   d_coeffs,
    output logic                            rd_en,
    output logic [AW-1:0]                   x_rd_addr,
    output logic [AW-1:0]                   y_rd_addr,
    input  logic signed [COEFF_WIDTH-1:0]   x_rd_data,
    input  logic signed [COEFF_WIDTH-1:0]   y_rd_data,
    output logic                            done,
    output logic [dtwl1_pkg::COST_W-1:0]    cost
);

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIST,
        S_DRAIN,
        S_CELL
    } state_t;

    state_t                         state_reg;
    logic [CW-1:0]                  c_reg;
    logic [IW-1:0]                  k_reg;
    logic [IW-1:0]                  i_reg;
    logic [AW-1:0]                  x_base_reg;
    logic [AW-1:0]                  y_base_reg;
    logic                           issue_vld_reg;
    logic [dtwl1_pkg::COST_W-1:0]   acc_reg;
    logic [dtwl1_pkg::COST_W-1:0]   left_reg;
    logic [dtwl1_pkg::COST_W-1:0]   diag_reg;
    logic                           done_reg;
    logic [dtwl1_pkg::COST_W-1:0]   cost_reg;

    logic [dtwl1_pkg::COST_W-1:0]   prev_mem [MAX_FRAMES];
    logic [dtwl1_pkg::COST_W-1:0]   up_reg;

    dtwl1_pkg::alu_op_t             alu_op;
    logic [dtwl1_pkg::COST_W-1:0]   best;
    logic [dtwl1_pkg::COST_W-1:0]   alu_sum;
    logic                           c_last;
    logic                           k_last;
    logic                           i_last;
    logic                           prev_rd_en;

    // loop end flags
    assign c_last = (DW'(c_reg) == d_coeffs - DW'(1));
    assign k_last = (FW'(k_reg) == m_frames - FW'(1));
    assign i_last = (FW'(i_reg) == n_frames - FW'(1));

    // store reads, one coefficient pair a cycle
    assign rd_en      = (state_reg == S_DIST);
    assign x_rd_addr  = x_base_reg + AW'(c_reg);
    assign y_rd_addr  = y_base_reg + AW'(c_reg);
    assign prev_rd_en = (state_reg == S_DIST) && (c_reg == '0);

    // best predecessor: border rows add along the edge, interior takes the minimum
    always_comb begin
        if (i_reg == '0) begin
            best = (k_reg == '0) ? '0 : left_reg;
        end else if (k_reg == '0) begin
            best = up_reg;
        end else begin
            best = up_reg;
            if (diag_reg < best) begin
                best = diag_reg;
            end
            if (left_reg < best) begin
                best = left_reg;
            end
        end
    end

    assign alu_op = (state_reg == S_CELL) ? dtwl1_pkg::ALU_ADD_BEST : dtwl1_pkg::ALU_ACC_DIFF;

    dtwl1_alu #(
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_alu (
        .op      (alu_op),
        .acc_in  (acc_reg),
        .coeff_a (x_rd_data),
        .coeff_b (y_rd_data),
        .best    (best),
        .sum     (alu_sum)
    );

    // previous row memory
    always_ff @(posedge aclk) begin
        if (state_reg == S_CELL) begin
            prev_mem[k_reg] <= alu_sum;
        end
        if (prev_rd_en) begin
            up_reg <= prev_mem[k_reg];
        end
    end

    // walk sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            issue_vld_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            done_reg      <= 1'b0;
            issue_vld_reg <= (state_reg == S_DIST);
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        state_reg  <= S_DIST;
                        c_reg      <= '0;
                        k_reg      <= '0;
                        i_reg      <= '0;
                        x_base_reg <= '0;
                        y_base_reg <= '0;
                        acc_reg    <= '0;
                        diag_reg   <= '0;
                    end
                end
                S_DIST: begin
                    if (issue_vld_reg) begin
                        acc_reg <= alu_sum;
                    end
                    c_reg <= c_reg + CW'(1);
                    if (c_last) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    acc_reg   <= alu_sum;
                    state_reg <= S_CELL;
                end
                S_CELL: begin
                    acc_reg   <= '0;
                    c_reg     <= '0;
                    left_reg  <= alu_sum;
                    state_reg <= S_DIST;
                    if (k_last) begin
                        k_reg      <= '0;
                        y_base_reg <= '0;
                        diag_reg   <= '0;
                        if (i_last) begin
                            state_reg <= S_IDLE;
                            done_reg  <= 1'b1;
                            cost_reg  <= alu_sum;
                        end else begin
                            i_reg      <= i_reg + IW'(1);
                            x_base_reg <= x_base_reg + AW'(d_coeffs);
                        end
                    end else begin
                        k_reg      <= k_reg + IW'(1);
                        y_base_reg <= y_base_reg + AW'(d_coeffs);
                        diag_reg   <= up_reg;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign cost = cost_reg;

endmodule

[bench/tb_dtw_l1_frame_alignment_cost_top.sv]
// tb_dtw_l1_frame_alignment_cost_top: self-checking bench for the dtw l1 frame alignment cost block
// predicts each warp cost from the loaded coefficient words and checks every m_ word against it
// depends on dtwl1_pkg and dtw_l1_frame_alignment_cost_top
`timescale 1ns / 100ps

module tb_dtw_l1_frame_alignment_cost_top;

    localparam int MAX_FRAMES    = 256;
    localparam int MAX_COEFFS    = 16;
    localparam int COEFF_W       = 16;
    localparam int STORE_DEPTH   = MAX_FRAMES * MAX_COEFFS;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES   = 64;
    localparam int RANDOM_WORDS  = 2000;
    localparam int HOLD_OFF_LEN  = 600;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [COEFF_W-1:0]              s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [dtwl1_pkg::COST_W-1:0]    m_tdata;
    logic                            cfg_we    = 1'b0;
    logic [dtwl1_pkg::CFG_AW-1:0]    cfg_addr  = dtwl1_pkg::CFG_X_FRAMES;
    logic [dtwl1_pkg::CFG_DW-1:0]    cfg_wdata = '0;

    // predictor state: register copies, coefficient stores, load counts
    logic [dtwl1_pkg::FRAMES_REG_W-1:0] pred_x_frames = dtwl1_pkg::X_FRAMES_RESET;
    logic [dtwl1_pkg::FRAMES_REG_W-1:0] pred_y_frames = dtwl1_pkg::Y_FRAMES_RESET;
    logic [dtwl1_pkg::COEFFS_REG_W-1:0] pred_coeffs   = dtwl1_pkg::COEFF_COUNT_RESET;
    logic signed [COEFF_W-1:0]          x_coeffs [STORE_DEPTH];
    logic signed [COEFF_W-1:0]          y_coeffs [STORE_DEPTH];
    int                                 x_loaded = 0;
    int                                 y_loaded = 0;
    logic [dtwl1_pkg::COST_W-1:0]       expected_costs [$];

    // bookkeeping
    int mismatch_count   = 0;
    int costs_checked    = 0;
    int words_loaded     = 0;
    int settings_written = 0;
    int stall_cycles     = 0;

    // sender and receiver pacing
    int burst_left       = 0;
    bit tx_gaps_on       = 1'b1;
    int hold_off_request = 0;
    int hold_left        = 0;
    int rx_cycle         = 0;
    logic [15:0] rx_pattern = 16'hFFFF;

    always #5 aclk = ~aclk;

    dtw_l1_frame_alignment_cost_top #(
        .MAX_FRAMES  (MAX_FRAMES),
        .MAX_COEFFS  (MAX_COEFFS),
        .COEFF_WIDTH (COEFF_W)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic int clamp_count(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned sat_cost(longint unsigned v);
        return (v > longint'(dtwl1_pkg::COST_MAX)) ? longint'(dtwl1_pkg::COST_MAX) : v;
    endfunction

    // full dtw walk over the loaded frames, one cost row kept
    function automatic logic [dtwl1_pkg::COST_W-1:0] warp_path_cost(int n, int m, int d);
        longint unsigned row [MAX_FRAMES];
        longint unsigned up, diag, best, frame_cost;
        int diff;
        for (int k = 0; k < MAX_FRAMES; k++) row[k] = 0;
        for (int i = 0; i < n; i++) begin
            diag = 0;
            for (int k = 0; k < m; k++) begin
                up = row[k];
                if (i == 0) begin
                    best = (k == 0) ? 0 : row[k-1];
                end else if (k == 0) begin
                    best = up;
                end else begin
                    best = up;
                    if (diag < best) best = diag;
                    if (row[k-1] < best) best = row[k-1];
                end
                // l1 distance of frame pair (i, k)
                frame_cost = 0;
                for (int c = 0; c < d; c++) begin
                    diff = int'(x_coeffs[i*d + c]) - int'(y_coeffs[k*d + c]);
                    if (diff < 0) diff = -diff;
                    frame_cost = sat_cost(frame_cost + longint'(diff));
                end
                row[k] = sat_cost(frame_cost + best);
                diag = up;
            end
        end
        return row[m-1][dtwl1_pkg::COST_W-1:0];
    endfunction

    // one accepted coefficient word: store it unless full, then check for completion
    function automatic void load_coeff(logic seq, logic [COEFF_W-1:0] raw);
        int n, m, d;
        n = clamp_count(int'(pred_x_frames), MAX_FRAMES);
        m = clamp_count(int'(pred_y_frames), MAX_FRAMES);
        d = clamp_count(int'(pred_coeffs), MAX_COEFFS);
        if (!seq) begin
            if (x_loaded < n*d) begin
                x_coeffs[x_loaded] = raw;
                x_loaded++;
                words_loaded++;
            end
        end else begin
            if (y_loaded < m*d) begin
                y_coeffs[y_loaded] = raw;
                y_loaded++;
                words_loaded++;
            end
        end
        if (x_loaded >= n*d && y_loaded >= m*d) begin
            expected_costs.push_back(warp_path_cost(n, m, d));
            x_loaded = 0;
            y_loaded = 0;
        end
    endfunction

    // handshake monitor: register writes, input words, cost checks, watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) begin
                case (cfg_addr)
                    dtwl1_pkg::CFG_X_FRAMES:
                        pred_x_frames = cfg_wdata[dtwl1_pkg::FRAMES_REG_W-1:0];
                    dtwl1_pkg::CFG_Y_FRAMES:
                        pred_y_frames = cfg_wdata[dtwl1_pkg::FRAMES_REG_W-1:0];
                    dtwl1_pkg::CFG_COEFF_COUNT:
                        pred_coeffs   = cfg_wdata[dtwl1_pkg::COEFFS_REG_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) load_coeff(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_costs.size() == 0) begin
                    $display("%0t: unexpected cost word: expected none, actual %0d",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    if (m_tdata !== expected_costs[0]) begin
                        $display("%0t: warp_cost mismatch: expected %0d, actual %0d",
                                 $time, expected_costs[0], m_tdata);
                        mismatch_count++;
                    end
                    void'(expected_costs.pop_front());
                    costs_checked++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d costs outstanding",
                     $time, stall_cycles, expected_costs.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: a randomly redrawn stall pattern, plus requested hold-offs
    always @(posedge aclk) begin
        rx_cycle++;
        if (hold_off_request != 0) begin
            hold_left = hold_off_request;
            hold_off_request = 0;
        end
        if (rx_cycle % 64 == 0)
            rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= rx_pattern[rx_cycle % 16];
        end
    end

    function automatic logic [COEFF_W-1:0] rand_coeff();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one word and wait for it to be taken; bursts end in random gaps
    task automatic send_word(input logic seq, input logic [COEFF_W-1:0] coeff);
        s_tvalid <= 1'b1;
        s_tuser  <= seq;
        s_tdata  <= coeff;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            if (tx_gaps_on) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    endtask

    // stop offering and wait until every predicted cost has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_costs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_registers(input logic [dtwl1_pkg::CFG_DW-1:0] x_reg,
                                     input logic [dtwl1_pkg::CFG_DW-1:0] y_reg,
                                     input logic [dtwl1_pkg::CFG_DW-1:0] d_reg);
        cfg_we    <= 1'b1;
        cfg_addr  <= dtwl1_pkg::CFG_X_FRAMES;
        cfg_wdata <= x_reg;
        @(posedge aclk);
        cfg_addr  <= dtwl1_pkg::CFG_Y_FRAMES;
        cfg_wdata <= y_reg;
        @(posedge aclk);
        cfg_addr  <= dtwl1_pkg::CFG_COEFF_COUNT;
        cfg_wdata <= d_reg;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        settings_written++;
    endtask

    // one pair of sequences: mostly interleaved, sometimes with dropped extras or cut short
    task automatic send_sequence_pair(input int n, input int m, input int d);
        int rem_x, rem_y, style;
        rem_x = n * d;
        rem_y = m * d;
        style = $urandom_range(0, 9);
        if (style == 9) begin
            if ($urandom_range(0, 1)) rem_x = $urandom_range(0, rem_x - 1);
            else rem_y = $urandom_range(0, rem_y - 1);
        end
        if (style == 7) begin
            repeat (rem_x) send_word(1'b0, rand_coeff());
            repeat ($urandom_range(1, 3)) send_word(1'b0, rand_coeff());
            repeat (rem_y) send_word(1'b1, rand_coeff());
        end else if (style == 8) begin
            repeat (rem_y) send_word(1'b1, rand_coeff());
            repeat ($urandom_range(1, 3)) send_word(1'b1, rand_coeff());
            repeat (rem_x) send_word(1'b0, rand_coeff());
        end else begin
            while (rem_x + rem_y > 0) begin
                if ($urandom_range(1, rem_x + rem_y) <= rem_x) begin
                    send_word(1'b0, rand_coeff());
                    rem_x--;
                end else begin
                    send_word(1'b1, rand_coeff());
                    rem_y--;
                end
            end
        end
    endtask

    // single-frame pairs at the coefficient extremes
    task automatic test_extreme_coefficients();
        wait_drained();
        program_registers(9'd1, 9'd1, 9'd1);
        send_word(1'b0, 16'h8000);
        send_word(1'b1, 16'h7FFF);
        send_word(1'b1, 16'h8000);
        send_word(1'b0, 16'h7FFF);
        send_word(1'b0, 16'h0000);
        send_word(1'b1, 16'h0000);
        send_word(1'b0, 16'hFFFF);
        send_word(1'b1, 16'h0001);
    endtask

    // words for a sequence that is already full are dropped
    task automatic test_full_sequence_drop();
        wait_drained();
        program_registers(9'd1, 9'd1, 9'd1);
        send_word(1'b0, 16'h1234);
        send_word(1'b0, 16'h7FFF);
        send_word(1'b1, 16'hF000);
        send_word(1'b1, 16'h0042);
        send_word(1'b1, 16'h8000);
        send_word(1'b1, 16'h7FFF);
        send_word(1'b0, 16'hFFC0);
    endtask

    // zero counts act as one; coeff_count keeps only its low bits
    task automatic test_register_limits();
        wait_drained();
        program_registers(9'd0, 9'd0, 9'd0);
        send_word(1'b0, 16'h8000);
        send_word(1'b1, 16'h0000);
        wait_drained();
        program_registers(9'd1, 9'd1, 9'h1E2);
        send_word(1'b0, 16'h0101);
        send_word(1'b1, 16'hFEFE);
        send_word(1'b0, 16'h8001);
        send_word(1'b1, 16'h7FFE);
    endtask

    // shrinking the frame count under a partial load completes the pair on the next word
    task automatic test_config_change_midload();
        wait_drained();
        program_registers(9'd2, 9'd1, 9'd2);
        send_word(1'b0, 16'h0100);
        send_word(1'b0, 16'hFF00);
        send_word(1'b1, 16'h0005);
        send_word(1'b1, 16'h8001);
        wait_drained();
        program_registers(9'd1, 9'd1, 9'd2);
        send_word(1'b1, 16'h7FFF);
    endtask

    // long receiver hold-off while the sender keeps going, then a full drain
    task automatic test_output_backpressure();
        wait_drained();
        program_registers(9'd2, 9'd2, 9'd2);
        tx_gaps_on = 1'b0;
        hold_off_request = HOLD_OFF_LEN;
        repeat (6) send_sequence_pair(2, 2, 2);
        wait_drained();
        tx_gaps_on = 1'b1;
    endtask

    // random settings, mostly small; the first phases hit the register extremes
    task automatic test_random_alignments();
        int start_words, phase, pairs, sel, n, m, d;
        logic [dtwl1_pkg::CFG_DW-1:0] x_reg, y_reg, d_reg;
        start_words = words_loaded;
        phase = 0;
        while (words_loaded - start_words < RANDOM_WORDS) begin
            sel = (phase < 4) ? phase : $urandom_range(0, 19);
            pairs = $urandom_range(2, 6);
            case (sel)
                0: begin
                    x_reg = $urandom_range(0, 1) ? 9'd256 : 9'h1FF;
                    y_reg = 9'($urandom_range(1, 2));
                    d_reg = 9'($urandom_range(1, 2));
                    pairs = 1;
                end
                1: begin
                    x_reg = 9'($urandom_range(1, 2));
                    y_reg = $urandom_range(0, 1) ? 9'd256 : 9'd300;
                    d_reg = 9'($urandom_range(1, 2));
                    pairs = 1;
                end
                2: begin
                    x_reg = 9'($urandom_range(1, 3));
                    y_reg = 9'($urandom_range(1, 3));
                    d_reg = $urandom_range(0, 1) ? 9'd16 : 9'($urandom_range(17, 31));
                end
                3: begin
                    x_reg = 9'($urandom_range(0, 1));
                    y_reg = 9'($urandom_range(0, 1));
                    d_reg = 9'($urandom_range(0, 1));
                end
                default: begin
                    x_reg = 9'($urandom_range(1, 6));
                    y_reg = 9'($urandom_range(1, 6));
                    d_reg = 9'($urandom_range(1, 8));
                end
            endcase
            wait_drained();
            program_registers(x_reg, y_reg, d_reg);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            n = clamp_count(int'(x_reg), MAX_FRAMES);
            m = clamp_count(int'(y_reg), MAX_FRAMES);
            d = clamp_count(int'(d_reg[dtwl1_pkg::COEFFS_REG_W-1:0]), MAX_COEFFS);
            repeat (pairs) begin
                send_sequence_pair(n, m, d);
                if ($urandom_range(0, 9) == 0) wait_drained();
            end
            phase++;
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extreme_coefficients();
        test_full_sequence_drop();
        test_register_limits();
        test_config_change_midload();
        test_output_backpressure();
        test_random_alignments();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d coefficient words stored under %0d register settings, %0d warp costs checked",
                 words_loaded, settings_written, costs_checked);
        if (expected_costs.size() != 0)
            $display("%0t: %0d expected costs never arrived", $time, expected_costs.size());
        if (mismatch_count == 0 && expected_costs.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/dtwl1_pkg.sv
hw/rtl/dtwl1_coeff_mem.sv
hw/rtl/dtwl1_alu.sv
hw/rtl/dtwl1_seq.sv
hw/rtl/dtw_l1_frame_alignment_cost_top.sv
bench/tb_dtw_l1_frame_alignment_cost_top.sv
